### hw/rtl/sdx_pkg.sv
// package: soundex encoder types, character constants and the letter-to-digit map
`timescale 1ns / 1ps

package sdx_pkg;

	localparam int CODE_LENGTH_DEF = 4;
	localparam int CODE_LENGTH_MAX = 16;
	// count width covers every legal code length, including the length itself
	localparam int CNT_W = $clog2(CODE_LENGTH_MAX + 1);

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CASE_OFFSET = 8'h20;
	localparam logic [2:0] DIGIT_NONE = 3'd0;

	typedef struct packed {
		logic [7:0]       ch;
		logic             has_ch;
		logic [CNT_W-1:0] total;
		logic [CNT_W-1:0] start;
	} sdx_job_t;

	function automatic logic [7:0] sdx_upper(input logic [7:0] b);
		logic [7:0] r;
		r = b;
		if (b inside {["a":"z"]}) begin
			r = b - CASE_OFFSET;
		end
		return r;
	endfunction

	function automatic logic [2:0] sdx_digit(input logic [7:0] b);
		logic [7:0] u;
		logic [2:0] d;
		u = sdx_upper(b);
		case (u) inside
			"B", "F", "P", "V": d = 3'd1;
			"C", "G", "J", "K", "Q", "S", "X", "Z": d = 3'd2;
			"D", "T": d = 3'd3;
			"L": d = 3'd4;
			"M", "N": d = 3'd5;
			"R": d = 3'd6;
			default: d = DIGIT_NONE;
		endcase
		return d;
	endfunction

endpackage

### hw/rtl/sdx_stream_if.sv
// interfaces: name byte stream and code character stream
`timescale 1ns / 1ps

interface sdx_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] letter;
	logic       name_end;

	modport source (output valid, output letter, output name_end, input ready);
	modport sink (input valid, input letter, input name_end, output ready);
endinterface

interface sdx_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] code_char;
	logic       code_done;

	modport source (output valid, output code_char, output code_done, input ready);
	modport sink (input valid, input code_char, input code_done, output ready);
endinterface

### hw/rtl/sdx_emitter.sv
// output register: drains a job (optional character plus pads), one per cycle when ready
`timescale 1ns / 1ps

module sdx_emitter
	import sdx_pkg::*;
#(
	parameter int CODE_LENGTH = CODE_LENGTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  sdx_job_t    job,
	output logic        take,
	sdx_out_if.source   code
);

	localparam logic [CNT_W-1:0] CODE_LEN_C = CNT_W'(CODE_LENGTH);

	logic [7:0]       ch_q;
	logic             has_ch_q;
	logic [CNT_W-1:0] remain_q;
	logic [CNT_W-1:0] pos_q;
	logic             fire;

	assign fire = code.valid && code.ready;
	// free now, or the last character of the job leaves this cycle
	assign take = (remain_q == '0) || (remain_q == CNT_W'(1) && code.ready);

	assign code.valid     = (remain_q != '0);
	assign code.code_char = has_ch_q ? ch_q : CHAR_ZERO;
	assign code.code_done = (pos_q + CNT_W'(1)) == CODE_LEN_C;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remain_q <= '0;
			has_ch_q <= 1'b0;
		end else if (load && take) begin
			remain_q <= job.total;
			has_ch_q <= job.has_ch;
		end else if (fire) begin
			remain_q <= remain_q - CNT_W'(1);
			has_ch_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && take) begin
			ch_q  <= job.ch;
			pos_q <= job.start;
		end else if (fire) begin
			pos_q <= pos_q + CNT_W'(1);
		end
	end

endmodule

### hw/rtl/soundex_code_encoder.sv
// top level: streaming american soundex encoder, one name byte per transaction
`timescale 1ns / 1ps

// Soundex encoder. Names arrive one ASCII byte per transaction on name_stream, with
// name_end set on the last byte; code characters leave one per transaction on
// code_stream, code_done marking the CODE_LENGTH-th one. The first byte goes out
// uppercased; later letters map to digits 1..6 and a digit goes out only when it
// differs from the previous digit and the code is not yet full. Vowels, H, W, Y and
// non-letters give nothing and leave the previous digit as it was. On the last byte
// the code is padded with '0'. Rate: one byte is accepted every cycle while results
// drain; a byte yields zero or one character, except a last byte, which yields up to
// CODE_LENGTH characters. The output register sends one character per cycle while
// code_stream is ready, so a name's last byte holds the stream until all have left.
// A byte passes the input register and then the output register. One byte can be
// taken into the input register while the output is stalled.

module soundex_code_encoder
	import sdx_pkg::*;
#(
	parameter int CODE_LENGTH = CODE_LENGTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	sdx_in_if.sink    name_stream,
	sdx_out_if.source code_stream
);

	localparam logic [CNT_W-1:0] CODE_LEN_C = CNT_W'(CODE_LENGTH);

	// input register
	logic       valid_s1;
	logic [7:0] letter_s1;
	logic       name_end_s1;

	// encoder state
	logic [2:0]       prev_q;
	logic [CNT_W-1:0] count_q;
	logic             first_q;

	logic [2:0]       dig;
	logic             emit;
	logic [CNT_W-1:0] cnt_after;
	logic [CNT_W-1:0] pads;
	sdx_job_t         job;
	logic             take;
	logic             move;

	assign move = valid_s1 && take;
	assign name_stream.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (name_stream.ready) begin
			valid_s1 <= name_stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (name_stream.ready && name_stream.valid) begin
			letter_s1   <= name_stream.letter;
			name_end_s1 <= name_stream.name_end;
		end
	end

	// work out what this byte emits and how many pads follow
	assign dig = sdx_digit(letter_s1);

	always_comb begin
		emit      = 1'b0;
		cnt_after = count_q;
		job       = '0;
		job.start = first_q ? '0 : count_q;
		if (first_q) begin
			emit      = 1'b1;
			job.ch    = sdx_upper(letter_s1);
			cnt_after = CNT_W'(1);
		end else if (count_q < CODE_LEN_C && dig != DIGIT_NONE && dig != prev_q) begin
			emit      = 1'b1;
			job.ch    = CHAR_ZERO + {5'b0, dig};
			cnt_after = count_q + CNT_W'(1);
		end
		// count never passes the code length, so this cannot wrap
		pads       = name_end_s1 ? (CODE_LEN_C - cnt_after) : '0;
		job.has_ch = emit;
		job.total  = pads + {{(CNT_W-1){1'b0}}, emit};
	end

	// state advances when the byte hands its job to the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= DIGIT_NONE;
			count_q <= '0;
			first_q <= 1'b1;
		end else if (move) begin
			if (name_end_s1) begin
				prev_q  <= DIGIT_NONE;
				count_q <= '0;
				first_q <= 1'b1;
			end else begin
				if (emit) begin
					prev_q <= dig;
				end
				count_q <= cnt_after;
				first_q <= 1'b0;
			end
		end
	end

	sdx_emitter #(
		.CODE_LENGTH(CODE_LENGTH)
	) u_emitter (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (move),
		.job    (job),
		.take   (take),
		.code   (code_stream)
	);

endmodule

### tb/soundex_code_encoder_tb.sv
// testbench: soundex_code_encoder against a cycle-free predictor of the soundex code stream
`timescale 1ns / 1ps

module soundex_code_encoder_tb
	import sdx_pkg::*;
;

	localparam int CODE_LEN = CODE_LENGTH_DEF;
	// quiet cycles (no transaction on either side) tolerated before giving up
	localparam int QUIET_LIMIT = 4000;
	localparam int PHASES = 4;
	localparam int BYTES_PER_PHASE = 55;
	localparam int DIRECTED_ROWS = 26;

	// one byte of a name, with an optional hand-written expectation
	// chars holds up to four characters, first one in the top byte;
	// done holds their code_done flags, first one in the top bit
	typedef struct packed {
		logic [7:0]  letter;
		logic        name_end;
		logic        typed;
		logic [2:0]  n_chars;
		logic [31:0] chars;
		logic [3:0]  done;
	} stim_row_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       done;
	} code_item_t;

	logic clk = 1'b0;
	logic arst_n;

	sdx_in_if  name_stream ();
	sdx_out_if code_stream ();

	soundex_code_encoder i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.name_stream (name_stream),
		.code_stream (code_stream)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// directed names, walked in order right after reset:
	//   one-byte names, two at the byte extremes (typed expectations),
	//   a name whose code fills before its last byte (trailing bytes dropped, no pad),
	//   a first-letter digit repeated by the second letter, a byte above 127 late in a name,
	//   a non-letter first byte, and a name where a vowel does not break a repeated digit
	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{"a",    1'b1, 1'b1, 3'd4, "A000",            4'b0001},
		'{8'hFF,  1'b1, 1'b1, 3'd4, {8'hFF, "000"},    4'b0001},
		'{8'h00,  1'b1, 1'b1, 3'd4, {8'h00, "000"},    4'b0001},
		'{"R",    1'b0, 1'b1, 3'd1, {"R", 24'h0},      4'b0000},
		'{"o",    1'b0, 1'b0, 3'd0, 32'h0,             4'b0000},
		'{"b",    1'b0, 1'b0, 3'd0, 32'h0,             4'b0000},
		'{"e",    1'b0, 1'b0, 3'd0, 32'h0,             4'b0000},
		'{"r",    1'b0, 1'b0, 3'd0, 32'h0,             4'b0000},
		'{"t",    1'b0, 1'b0, 3'd0, 32'h0,             4'b0000},
		'{"s",    1'b0, 1'b0, 3'd0, 32'h0,             4'b0000},
		'{"n",    1'b1, 1'b0, 3'd0, 32'h0,             4'b0000},
		'{"P",    1'b0, 1'b0, 3'd0, 32'h0,             4'b0000},
		'{"f",    1'b0, 1'b0, 3'd0, 32'h0,             4'b0000},
		'{"i",    1'b0, 1'b0, 3'd0, 32'h0,             4'b0000},
		'{"S",    1'b0, 1'b0, 3'd0, 32'h0,             4'b0000},
		'{"t",    1'b0, 1'b0, 3'd0, 32'h0,             4'b0000},
		'{"e",    1'b0, 1'b0, 3'd0, 32'h0,             4'b0000},
		'{"r",    1'b0, 1'b0, 3'd0, 32'h0,             4'b0000},
		'{8'hE1,  1'b1, 1'b0, 3'd0, 32'h0,             4'b0000},
		'{"@",    1'b0, 1'b1, 3'd1, {"@", 24'h0},      4'b0000},
		'{"M",    1'b0, 1'b0, 3'd0, 32'h0,             4'b0000},
		'{"L",    1'b1, 1'b0, 3'd0, 32'h0,             4'b0000},
		'{"b",    1'b0, 1'b0, 3'd0, 32'h0,             4'b0000},
		'{"a",    1'b0, 1'b0, 3'd0, 32'h0,             4'b0000},
		'{"v",    1'b0, 1'b0, 3'd0, 32'h0,             4'b0000},
		'{8'h7F,  1'b1, 1'b0, 3'd0, 32'h0,             4'b0000}
	};

	// idle and stall rates per phase, percent of cycles
	localparam int PHASE_IDLE [PHASES]  = '{0, 53, 0, 25};
	localparam int PHASE_STALL [PHASES] = '{0, 0, 53, 25};

	int send_idle_pct = 0;
	int stall_pct = 0;
	int bytes_sent = 0;
	int mismatches = 0;
	int quiet_cycles = 0;

	// rows offered to the block, popped when the block takes them
	stim_row_t  offered_bytes [$];
	// code characters still owed by the block, oldest first
	code_item_t code_expect [$];
	// characters produced by one predictor step
	code_item_t step_codes [$];

	// predictor state
	logic [2:0] prev_digit = DIGIT_NONE;
	int         code_count = 0;
	logic       at_name_start = 1'b1;

	function automatic logic [7:0] to_upper(input logic [7:0] b);
		return (b >= "a" && b <= "z") ? b - 8'd32 : b;
	endfunction

	// soundex letter classes; anything else, including bytes above 127, has no digit
	function automatic logic [2:0] soundex_digit(input logic [7:0] b);
		case (to_upper(b))
			"B", "F", "P", "V": return 3'd1;
			"C", "G", "J", "K", "Q", "S", "X", "Z": return 3'd2;
			"D", "T": return 3'd3;
			"L": return 3'd4;
			"M", "N": return 3'd5;
			"R": return 3'd6;
			default: return DIGIT_NONE;
		endcase
	endfunction

	function automatic void emit_code(input logic [7:0] c);
		code_count++;
		step_codes.push_back('{c, code_count == CODE_LEN});
	endfunction

	// advance the predictor by one accepted byte, filling step_codes
	function automatic void soundex_step(input logic [7:0] b, input logic last);
		logic [2:0] d;
		step_codes.delete();
		if (at_name_start) begin
			code_count = 0;
			emit_code(to_upper(b));
			prev_digit = soundex_digit(b);
			at_name_start = 1'b0;
		end else if (code_count < CODE_LEN) begin
			// vowels and other silent bytes leave prev_digit alone
			d = soundex_digit(b);
			if (d != DIGIT_NONE && d != prev_digit) begin
				emit_code(CHAR_ZERO + {5'd0, d});
				prev_digit = d;
			end
		end
		if (last) begin
			// pad short codes with '0'; a full code gets nothing more
			while (code_count < CODE_LEN)
				emit_code(CHAR_ZERO);
			prev_digit = DIGIT_NONE;
			code_count = 0;
			at_name_start = 1'b1;
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
		mismatches++;
		$display("%0t mismatch: %s got %h want %h", $realtime, what, got, want);
	endtask

	// monitor: predict on every byte the block takes, check every character it gives,
	// drive the receiver ready and watch for a hang
	always @(posedge clk) begin : monitor
		stim_row_t  note;
		code_item_t want;
		int k;
		if (arst_n) begin
			quiet_cycles++;
			if (name_stream.valid && name_stream.ready) begin
				quiet_cycles = 0;
				note = offered_bytes.pop_front();
				soundex_step(name_stream.letter, name_stream.name_end);
				if (note.typed) begin
					for (k = 0; k < note.n_chars; k++)
						code_expect.push_back('{note.chars[31 - 8 * k -: 8], note.done[3 - k]});
				end else begin
					foreach (step_codes[k])
						code_expect.push_back(step_codes[k]);
				end
			end
			if (code_stream.valid && code_stream.ready) begin
				quiet_cycles = 0;
				if (code_expect.size() == 0) begin
					report_mismatch("code character with none expected", code_stream.code_char, 8'h00);
				end else begin
					want = code_expect.pop_front();
					if (code_stream.code_char !== want.ch)
						report_mismatch("code_char", code_stream.code_char, want.ch);
					if (code_stream.code_done !== want.done)
						report_mismatch("code_done", {7'd0, code_stream.code_done}, {7'd0, want.done});
				end
			end
		end
		code_stream.ready <= ($urandom_range(0, 99) >= stall_pct);
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("soundex_code_encoder_tb failed");
			$finish;
		end
	end

	// present one byte and hold it until the block takes it
	// this task lowers valid only while idling, so back-to-back bytes keep it high
	task automatic offer_byte(input stim_row_t r);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			name_stream.valid <= 1'b0;
			@(posedge clk);
		end
		offered_bytes.push_back(r);
		name_stream.valid    <= 1'b1;
		name_stream.letter   <= r.letter;
		name_stream.name_end <= r.name_end;
		do
			@(posedge clk);
		while (!name_stream.ready);
		bytes_sent++;
	endtask

	// mostly letters of either case, with a sprinkling of arbitrary bytes;
	// a few long names overflow the code and exercise the dropped tail
	task automatic send_random_name();
		int len;
		int k;
		logic [7:0] b;
		stim_row_t r;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 14) : $urandom_range(1, 7);
		for (k = 0; k < len; k++) begin
			if ($urandom_range(0, 99) < 85) begin
				b = "A" + 8'($urandom_range(0, 25));
				if ($urandom_range(0, 1))
					b = b + CASE_OFFSET;
			end else begin
				b = 8'($urandom_range(0, 255));
			end
			r = '{b, k == len - 1, 1'b0, 3'd0, 32'h0, 4'h0};
			offer_byte(r);
		end
	endtask

	// hold off the sender until every owed character has come out
	task automatic drain_codes();
		name_stream.valid <= 1'b0;
		do
			@(posedge clk);
		while (code_expect.size() != 0);
	endtask

	initial begin
		int ph;
		int k;
		int target;
		arst_n               = 1'b0;
		name_stream.valid    = 1'b0;
		name_stream.letter   = 8'h00;
		name_stream.name_end = 1'b0;
		code_stream.ready    = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed rows, no idling on either side
		for (k = 0; k < DIRECTED_ROWS; k++)
			offer_byte(DIRECTED[k]);
		drain_codes();

		// random names under each idle/stall mix, draining between mixes
		for (ph = 0; ph < PHASES; ph++) begin
			send_idle_pct = PHASE_IDLE[ph];
			stall_pct     = PHASE_STALL[ph];
			target        = bytes_sent + BYTES_PER_PHASE;
			while (bytes_sent < target)
				send_random_name();
			drain_codes();
		end

		// let any stray character surface before the verdict
		stall_pct = 0;
		repeat (8) @(posedge clk);
		if (code_expect.size() != 0)
			report_mismatch("code characters never delivered", 8'(code_expect.size()), 8'h00);
		if (mismatches == 0) begin
			$display("soundex_code_encoder_tb passed");
		end else begin
			$display("soundex_code_encoder_tb failed");
		end
		$finish;
	end

endmodule
